>>> sv/nsv_pkg.sv
// ----------------------------------------------------------------------------
// nsv_pkg: shared types and constants for the NMEA sentence validator
// Phase encoding, status and kind codes, ASCII codes, address lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package nsv_pkg;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BODY,
      PH_HEX1,
      PH_HEX2
   } phase_type;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_CHECKSUM   = 3'd1;
   localparam logic [2:0] ST_UNKNOWN    = 3'd2;
   localparam logic [2:0] ST_FIELDS     = 3'd3;
   localparam logic [2:0] ST_INCOMPLETE = 3'd4;

   localparam int unsigned NUM_KINDS    = 10;
   localparam logic [3:0]  KIND_UNKNOWN = 4'd10;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   localparam logic [39:0] TYPE_NAMES [NUM_KINDS] = '{
      "GPGGA", "GPGSA", "GPGSV", "GPRMC", "GPVTG",
      "GPGLL", "GPZDA", "GPGST", "GPHDT", "GPGRS"
   };

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] sentence_kind;
      logic [4:0] field_total;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
   } result_type;

   // {valid, value}; valid low for a non-hex byte
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end
      return r;
   endfunction

   function automatic logic [3:0] classify(input logic [39:0] addr,
                                           input logic [2:0]  len,
                                           input logic        has_comma);
      logic [3:0] k;
      k = KIND_UNKNOWN;
      if (has_comma && len == 3'd5) begin
         for (int i = NUM_KINDS - 1; i >= 0; i--) begin
            if (addr == TYPE_NAMES[i]) k = 4'(i);
         end
      end
      return k;
   endfunction

   function automatic logic [4:0] expected_fields(input logic [3:0] kind);
      logic [4:0] r;
      case (kind)
         4'd0:    r = 5'd16;
         4'd1:    r = 5'd19;
         4'd2:    r = 5'd20;
         4'd3:    r = 5'd12;
         4'd4:    r = 5'd10;
         4'd5:    r = 5'd8;
         4'd6:    r = 5'd7;
         4'd7:    r = 5'd9;
         4'd8:    r = 5'd3;
         4'd9:    r = 5'd16;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/nsv_input_reg.sv
// ----------------------------------------------------------------------------
// nsv_input_reg: input byte register
// Captures one byte per cycle while req_ready is high; holds it until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nsv_input_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       advance,
   output logic            byte_valid,
   output logic [7:0]      rx_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_ready) begin
         valid_in = req_valid;
         byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign rx_byte    = byte_ff;

endmodule

`default_nettype wire

>>> sv/nsv_parser.sv
// ----------------------------------------------------------------------------
// nsv_parser: sentence state and verdict logic
// Updates phase, checksum, address and comma count for each consumed byte
// and flags the byte that closes a sentence.
// ----------------------------------------------------------------------------
`default_nettype none

module nsv_parser #(
   parameter int unsigned MAX_FIELDS = 31
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] rx_byte,
   output logic            res_valid,
   output nsv_pkg::result_type result
);

   localparam int unsigned CW = $clog2(MAX_FIELDS);
   localparam logic [CW-1:0] COMMA_MAX = CW'(MAX_FIELDS - 1);

   nsv_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  xor_ff,   xor_in;
   logic [39:0] addr_ff,  addr_in;
   logic [2:0]  len_ff,   len_in;
   logic [CW-1:0] comma_ff, comma_in;
   logic [3:0]  hi_ff,    hi_in;

   logic          is_dollar, is_eol, is_star, is_comma;
   logic [4:0]    hexv;
   logic [3:0]    kind;
   logic [CW:0]   total;
   logic [7:0]    received;

   assign is_dollar = (rx_byte == nsv_pkg::CH_DOLLAR);
   assign is_eol    = (rx_byte == nsv_pkg::CH_CR) || (rx_byte == nsv_pkg::CH_LF);
   assign is_star   = (rx_byte == nsv_pkg::CH_STAR);
   assign is_comma  = (rx_byte == nsv_pkg::CH_COMMA);
   assign hexv      = nsv_pkg::hex_value(rx_byte);
   assign kind      = nsv_pkg::classify(addr_ff, len_ff, comma_ff != '0);
   assign total     = {1'b0, comma_ff} + (CW+1)'(1);
   assign received  = {hi_ff, hexv[3:0]};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         nsv_pkg::PH_BODY: begin
            if (is_dollar)    phase_in = nsv_pkg::PH_BODY;
            else if (is_eol)  phase_in = nsv_pkg::PH_IDLE;
            else if (is_star) phase_in = nsv_pkg::PH_HEX1;
         end
         nsv_pkg::PH_HEX1: begin
            if (!hexv[4])     phase_in = is_dollar ? nsv_pkg::PH_BODY : nsv_pkg::PH_IDLE;
            else              phase_in = nsv_pkg::PH_HEX2;
         end
         nsv_pkg::PH_HEX2: begin
            if (!hexv[4] && is_dollar) phase_in = nsv_pkg::PH_BODY;
            else                       phase_in = nsv_pkg::PH_IDLE;
         end
         default: begin
            phase_in = is_dollar ? nsv_pkg::PH_BODY : nsv_pkg::PH_IDLE;
         end
      endcase
   end

   // sentence data and result
   always_comb begin
      logic open_new;
      open_new = 1'b0;
      xor_in   = xor_ff;
      addr_in  = addr_ff;
      len_in   = len_ff;
      comma_in = comma_ff;
      hi_in    = hi_ff;
      res_valid              = 1'b0;
      result.status          = nsv_pkg::ST_INCOMPLETE;
      result.sentence_kind   = kind;
      result.field_total     = total[4:0];
      result.computed_sum    = xor_ff;
      result.received_sum    = 8'd0;
      case (phase_ff)
         nsv_pkg::PH_BODY: begin
            if (is_dollar) begin
               open_new = 1'b1;
            end else if (is_eol) begin
               res_valid = 1'b1;
            end else if (!is_star) begin
               xor_in = xor_ff ^ rx_byte;
               if (is_comma) begin
                  if (comma_ff < COMMA_MAX) comma_in = comma_ff + CW'(1);
               end else if (comma_ff == '0) begin
                  if (len_ff < 3'd5) begin
                     addr_in = {addr_ff[31:0], rx_byte};
                     len_in  = len_ff + 3'd1;
                  end else begin
                     len_in  = 3'd6;
                  end
               end
            end
         end
         nsv_pkg::PH_HEX1, nsv_pkg::PH_HEX2: begin
            if (!hexv[4]) begin
               res_valid = 1'b1;
               open_new  = is_dollar;
            end else if (phase_ff == nsv_pkg::PH_HEX1) begin
               hi_in = hexv[3:0];
            end else begin
               res_valid           = 1'b1;
               result.received_sum = received;
               if (kind == nsv_pkg::KIND_UNKNOWN)
                  result.status = nsv_pkg::ST_UNKNOWN;
               else if (received != xor_ff)
                  result.status = nsv_pkg::ST_CHECKSUM;
               else if (total != (CW+1)'(nsv_pkg::expected_fields(kind)))
                  result.status = nsv_pkg::ST_FIELDS;
               else
                  result.status = nsv_pkg::ST_OK;
            end
         end
         default: begin
            open_new = is_dollar;
         end
      endcase
      if (open_new) begin
         xor_in   = 8'd0;
         addr_in  = 40'd0;
         len_in   = 3'd0;
         comma_in = '0;
         hi_in    = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= nsv_pkg::PH_IDLE;
         xor_ff   <= 8'd0;
         addr_ff  <= 40'd0;
         len_ff   <= 3'd0;
         comma_ff <= '0;
         hi_ff    <= 4'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         addr_ff  <= addr_in;
         len_ff   <= len_in;
         comma_ff <= comma_in;
         hi_ff    <= hi_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/nsv_result_reg.sv
// ----------------------------------------------------------------------------
// nsv_result_reg: result register
// Holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nsv_result_reg (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   load,
   input  wire nsv_pkg::result_type result,
   output logic        free,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output nsv_pkg::result_type held
);

   logic                valid_ff, valid_in;
   nsv_pkg::result_type data_ff,  data_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign held      = data_ff;

endmodule

`default_nettype wire

>>> sv/nmea_sentence_validator.sv
// ----------------------------------------------------------------------------
// nmea_sentence_validator: NMEA 0183 sentence checksum and type checker
// Bytes of the stream enter on the req_ channel, one per item. A '$' opens a
// sentence; the block tracks the XOR checksum, the address and the field
// count, and emits one verdict on the rsp_ channel when a sentence ends
// (after the second checksum digit, on CR/LF, or on a bad checksum digit).
// Bytes outside a sentence produce no item.
// A byte that closes a sentence passes the input register, then the result
// register, before its result shows at rsp_valid.
// Throughput: one byte per cycle unless stalled; the input register frees
// whenever the result register is empty or being read, so a stall on rsp_ready
// holds at most one pending byte plus one result before req_ready drops.
// Reset (synchronous, active high) empties both registers and returns the
// parser to idle, outside any sentence, with checksum and counts cleared.
// field_total shows commas plus one, saturating at MAX_FIELDS, low 5 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_validator #(
   parameter int unsigned MAX_FIELDS = 31
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [3:0]      rsp_sentence_kind,
   output logic [4:0]      rsp_field_total,
   output logic [7:0]      rsp_computed_sum,
   output logic [7:0]      rsp_received_sum
);

   logic                byte_valid;
   logic [7:0]          rx_byte;
   logic                advance;
   logic                out_free;
   logic                res_valid;
   nsv_pkg::result_type result;
   nsv_pkg::result_type held;

   assign advance = byte_valid && out_free;

   nsv_input_reg u_input_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .rx_byte     (rx_byte)
   );

   nsv_parser #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rx_byte   (rx_byte),
      .res_valid (res_valid),
      .result    (result)
   );

   nsv_result_reg u_result_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .held      (held)
   );

   assign rsp_status        = held.status;
   assign rsp_sentence_kind = held.sentence_kind;
   assign rsp_field_total   = held.field_total;
   assign rsp_computed_sum  = held.computed_sum;
   assign rsp_received_sum  = held.received_sum;

endmodule

`default_nettype wire

>>> tb/tb_nmea_sentence_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_sentence_validator: self-checking bench for the NMEA validator
// A byte-level parser model predicts each verdict. A short table of hand
// written sentences runs first, followed by generated sentences of every
// known type with good and bad checksums, wrong field counts, truncation,
// bad digits and line noise. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_validator;

   localparam int MAX_FIELDS   = 31;
   localparam int LIVE_BYTES   = 1250;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_AFTER  = 1050;
   localparam int DIR_ROWS     = 11;
   localparam logic [7:0] NUL_MARK = 8'h5E;   // '^' in the table stands for 0x00

   localparam logic [39:0] ADDR_NAMES [10] = '{
      "GPGGA", "GPGSA", "GPGSV", "GPRMC", "GPVTG",
      "GPGLL", "GPZDA", "GPGST", "GPHDT", "GPGRS"
   };
   localparam logic [4:0] FIELDS_FOR_KIND [10] = '{
      5'd16, 5'd19, 5'd20, 5'd12, 5'd10, 5'd8, 5'd7, 5'd9, 5'd3, 5'd16
   };

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [2:0] rsp_status;
   logic [3:0] rsp_sentence_kind;
   logic [4:0] rsp_field_total;
   logic [7:0] rsp_computed_sum;
   logic [7:0] rsp_received_sum;

   nmea_sentence_validator #(.MAX_FIELDS(MAX_FIELDS)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_sentence_kind (rsp_sentence_kind),
      .rsp_field_total   (rsp_field_total),
      .rsp_computed_sum  (rsp_computed_sum),
      .rsp_received_sum  (rsp_received_sum)
   );

   // directed sentences; typed rows carry the verdict of their first result
   string dir_text [DIR_ROWS] = '{
      "x\r\n",
      "$*00",
      "$GPHDT,,*4F",
      "$GPHDT,,*4e",
      "$GPHDT,*63",
      "$A\r",
      "$^\377*G",
      "$G$*00",
      "$GPHDT,*1$",
      "GPGLL,,,,,,,*7c",
      "$GPZDA,1,2,3,4,5,6*3A"
   };
   localparam bit DIR_TYPED [DIR_ROWS] = '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0};
   nsv_pkg::result_type dir_want [DIR_ROWS] = '{
      '0,
      '{nsv_pkg::ST_UNKNOWN,    nsv_pkg::KIND_UNKNOWN, 5'd1, 8'h00, 8'h00},
      '{nsv_pkg::ST_OK,         4'd8,                  5'd3, 8'h4F, 8'h4F},
      '{nsv_pkg::ST_CHECKSUM,   4'd8,                  5'd3, 8'h4F, 8'h4E},
      '{nsv_pkg::ST_FIELDS,     4'd8,                  5'd2, 8'h63, 8'h63},
      '{nsv_pkg::ST_INCOMPLETE, nsv_pkg::KIND_UNKNOWN, 5'd1, 8'h41, 8'h00},
      '{nsv_pkg::ST_INCOMPLETE, nsv_pkg::KIND_UNKNOWN, 5'd1, 8'hFF, 8'h00},
      '{nsv_pkg::ST_UNKNOWN,    nsv_pkg::KIND_UNKNOWN, 5'd1, 8'h00, 8'h00},
      '{nsv_pkg::ST_INCOMPLETE, 4'd8,                  5'd2, 8'h63, 8'h00},
      '{nsv_pkg::ST_OK,         4'd5,                  5'd8, 8'h7C, 8'h7C},
      '0
   };

   // parser state mirrored by the bench
   nsv_pkg::phase_type sp_phase = nsv_pkg::PH_IDLE;
   logic [7:0]  sp_xor    = 8'h00;
   logic [39:0] sp_addr   = '0;
   logic [2:0]  sp_alen   = 3'd0;
   logic [4:0]  sp_commas = 5'd0;
   logic [3:0]  sp_hi     = 4'd0;

   nsv_pkg::result_type pending_verdicts [$];
   logic [7:0]          sentence_bytes [$];
   bit                  typed_pending = 1'b0;
   nsv_pkg::result_type typed_want;

   bit hold_req    = 1'b0;
   bit quiet       = 1'b0;
   bit sender_gaps = 1'b1;

   int mismatches      = 0;
   int live_bytes      = 0;
   int verdicts_queued = 0;
   int verdicts_seen   = 0;
   int sat_hits        = 0;
   int status_hits [5] = '{0, 0, 0, 0, 0};
   bit kind_seen [16];

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_nmea_sentence_validator: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic int digit_value(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 8'h30;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 8'h41 + 10;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 8'h61 + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [3:0] kind_now();
      if (sp_commas == 5'd0 || sp_alen != 3'd5) return nsv_pkg::KIND_UNKNOWN;
      for (int k = 0; k < 10; k++) begin
         if (sp_addr == ADDR_NAMES[k]) return 4'(k);
      end
      return nsv_pkg::KIND_UNKNOWN;
   endfunction

   function automatic nsv_pkg::result_type snapshot(input logic [2:0] st,
                                                    input logic [7:0] rx);
      nsv_pkg::result_type v;
      v.status        = st;
      v.sentence_kind = kind_now();
      v.field_total   = 5'(sp_commas + 5'd1);
      v.computed_sum  = sp_xor;
      v.received_sum  = rx;
      return v;
   endfunction

   task automatic start_sentence();
      sp_phase  = nsv_pkg::PH_BODY;
      sp_xor    = 8'h00;
      sp_addr   = '0;
      sp_alen   = 3'd0;
      sp_commas = 5'd0;
      sp_hi     = 4'd0;
   endtask

   task automatic parse_byte(input logic [7:0] b, output bit got,
                             output nsv_pkg::result_type v);
      int         d;
      logic [7:0] rx;
      logic [3:0] kind;
      logic [2:0] st;
      got = 1'b0;
      v   = '0;
      d   = digit_value(b);
      case (sp_phase)
         nsv_pkg::PH_BODY: begin
            if (b == nsv_pkg::CH_DOLLAR) begin
               start_sentence();
            end else if (b == nsv_pkg::CH_CR || b == nsv_pkg::CH_LF) begin
               v        = snapshot(nsv_pkg::ST_INCOMPLETE, 8'h00);
               got      = 1'b1;
               sp_phase = nsv_pkg::PH_IDLE;
            end else if (b == nsv_pkg::CH_STAR) begin
               sp_phase = nsv_pkg::PH_HEX1;
            end else begin
               sp_xor ^= b;
               if (b == nsv_pkg::CH_COMMA) begin
                  if (int'(sp_commas) + 1 < MAX_FIELDS) sp_commas++;
               end else if (sp_commas == 5'd0) begin
                  // address: first five bytes kept, anything longer marked as length 6
                  if (sp_alen < 3'd5) begin
                     sp_addr = {sp_addr[31:0], b};
                     sp_alen++;
                  end else begin
                     sp_alen = 3'd6;
                  end
               end
            end
         end
         nsv_pkg::PH_HEX1, nsv_pkg::PH_HEX2: begin
            if (d < 0) begin
               v        = snapshot(nsv_pkg::ST_INCOMPLETE, 8'h00);
               got      = 1'b1;
               sp_phase = nsv_pkg::PH_IDLE;
               if (b == nsv_pkg::CH_DOLLAR) start_sentence();
            end else if (sp_phase == nsv_pkg::PH_HEX1) begin
               sp_hi    = 4'(d);
               sp_phase = nsv_pkg::PH_HEX2;
            end else begin
               rx   = {sp_hi, 4'(d)};
               kind = kind_now();
               if (kind == nsv_pkg::KIND_UNKNOWN) st = nsv_pkg::ST_UNKNOWN;
               else if (rx != sp_xor) st = nsv_pkg::ST_CHECKSUM;
               else if (5'(sp_commas + 5'd1) != FIELDS_FOR_KIND[kind]) st = nsv_pkg::ST_FIELDS;
               else st = nsv_pkg::ST_OK;
               v        = snapshot(st, rx);
               got      = 1'b1;
               sp_phase = nsv_pkg::PH_IDLE;
            end
         end
         default: begin
            if (b == nsv_pkg::CH_DOLLAR) start_sentence();
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      bit                  got;
      nsv_pkg::result_type v;
      if (sender_gaps && !quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      // ready is stable by the falling edge; the item moves at the next rising one
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (sp_phase != nsv_pkg::PH_IDLE || b == nsv_pkg::CH_DOLLAR) live_bytes++;
      parse_byte(b, got, v);
      if (got) begin
         verdicts_queued++;
         if (typed_pending) begin
            pending_verdicts = {pending_verdicts, typed_want};
            typed_pending = 1'b0;
         end else begin
            pending_verdicts = {pending_verdicts, v};
         end
      end
   endtask

   function automatic logic [7:0] field_char();
      logic [7:0] c;
      do begin
         c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(8'h20, 8'h7E));
      end while (c == nsv_pkg::CH_DOLLAR || c == nsv_pkg::CH_STAR ||
                 c == nsv_pkg::CH_COMMA || c == nsv_pkg::CH_CR ||
                 c == nsv_pkg::CH_LF);
      return c;
   endfunction

   task automatic build_fragment();
      int          pick;
      int          kind;
      int          alen;
      int          ncomma;
      int          cut;
      int          shape;
      bit          use_name;
      bit          lower;
      logic [7:0]  sum;
      logic [7:0]  c;
      logic [7:0]  rx;
      sentence_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick >= 92) begin
         // line noise, full byte range
         repeat ($urandom_range(1, 8)) begin
            c = 8'($urandom_range(0, 255));
            sentence_bytes = {sentence_bytes, c};
         end
         return;
      end
      sentence_bytes = {sentence_bytes, nsv_pkg::CH_DOLLAR};
      sum      = 8'h00;
      kind     = $urandom_range(0, 9);
      shape    = $urandom_range(0, 19);
      use_name = (shape < 16);
      alen     = (shape < 18) ? 5 : $urandom_range(0, 8);
      for (int i = 0; i < alen; i++) begin
         c = use_name ? ADDR_NAMES[kind][8 * (4 - i) +: 8] : 8'($urandom_range(8'h41, 8'h5A));
         sentence_bytes = {sentence_bytes, c};
         sum ^= c;
      end
      ncomma = ($urandom_range(0, 9) < 7) ? int'(FIELDS_FOR_KIND[kind]) - 1
                                          : $urandom_range(0, 36);
      for (int i = 0; i < ncomma; i++) begin
         sentence_bytes = {sentence_bytes, nsv_pkg::CH_COMMA};
         sum ^= nsv_pkg::CH_COMMA;
         repeat ($urandom_range(0, 2)) begin
            c = field_char();
            sentence_bytes = {sentence_bytes, c};
            sum ^= c;
         end
      end
      if (pick >= 70 && pick < 86) begin
         // cut short: line end in the body, or a silent abandon before the next '$'
         cut = $urandom_range(1, sentence_bytes.size());
         while (sentence_bytes.size() > cut) void'(sentence_bytes.pop_back());
         if (pick < 78) begin
            c = $urandom_range(0, 1) ? nsv_pkg::CH_CR : nsv_pkg::CH_LF;
            sentence_bytes = {sentence_bytes, c};
         end
         return;
      end
      sentence_bytes = {sentence_bytes, nsv_pkg::CH_STAR};
      lower = 1'($urandom_range(0, 1));
      if (pick >= 86) begin
         if ($urandom_range(0, 1)) sentence_bytes = {sentence_bytes, hex_char(sum[7:4], lower)};
         if ($urandom_range(0, 9) < 3) begin
            c = nsv_pkg::CH_DOLLAR;
         end else begin
            do c = 8'($urandom_range(0, 255)); while (digit_value(c) >= 0);
         end
         sentence_bytes = {sentence_bytes, c};
         return;
      end
      rx = ($urandom_range(0, 99) < 85) ? sum : 8'($urandom_range(0, 255));
      sentence_bytes = {sentence_bytes, hex_char(rx[7:4], lower)};
      sentence_bytes = {sentence_bytes, hex_char(rx[3:0], 1'($urandom_range(0, 1)))};
      if ($urandom_range(0, 1)) begin
         sentence_bytes = {sentence_bytes, nsv_pkg::CH_CR, nsv_pkg::CH_LF};
      end
   endtask

   task automatic check_verdict();
      nsv_pkg::result_type want;
      if (pending_verdicts.size() == 0) begin
         report_mismatch($sformatf("unexpected verdict status %0d kind %0d sum %h",
                                   rsp_status, rsp_sentence_kind, rsp_computed_sum));
         return;
      end
      want = pending_verdicts.pop_front();
      verdicts_seen++;
      if (want.status <= nsv_pkg::ST_INCOMPLETE) status_hits[want.status]++;
      kind_seen[want.sentence_kind] = 1'b1;
      if (want.field_total == 5'(MAX_FIELDS)) sat_hits++;
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
      if (rsp_sentence_kind !== want.sentence_kind)
         report_mismatch($sformatf("kind got %0d want %0d",
                                   rsp_sentence_kind, want.sentence_kind));
      if (rsp_field_total !== want.field_total)
         report_mismatch($sformatf("field_total got %0d want %0d",
                                   rsp_field_total, want.field_total));
      if (rsp_computed_sum !== want.computed_sum)
         report_mismatch($sformatf("computed_sum got %h want %h",
                                   rsp_computed_sum, want.computed_sum));
      if (rsp_received_sum !== want.received_sum)
         report_mismatch($sformatf("received_sum got %h want %h",
                                   rsp_received_sum, want.received_sum));
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_verdict();
   end

   // result side: random stalls, one long hold-off, always ready at the end
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [7:0] c;
      bit         hold_done;
      int         kinds;
      hold_done = 1'b0;
      kinds     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         typed_pending = DIR_TYPED[r];
         typed_want    = dir_want[r];
         for (int i = 0; i < dir_text[r].len(); i++) begin
            c = dir_text[r][i];
            if (c == NUL_MARK) c = 8'h00;
            send_byte(c);
         end
         if (typed_pending) report_mismatch($sformatf("table row %0d closed no sentence", r));
         typed_pending = 1'b0;
      end

      while (live_bytes < LIVE_BYTES) begin
         if (live_bytes > HOLD_AT && !hold_done) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
         end
         if (live_bytes > QUIET_AFTER) quiet = 1'b1;
         sender_gaps = ($urandom_range(0, 2) != 0);
         build_fragment();
         foreach (sentence_bytes[i]) send_byte(sentence_bytes[i]);
      end
      req_valid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      foreach (kind_seen[k]) if (kind_seen[k]) kinds++;
      $display("run covered %0d sentence bytes and %0d verdicts: ok %0d, checksum %0d, %s",
               live_bytes, verdicts_seen, status_hits[0], status_hits[1],
               $sformatf("unknown %0d, field count %0d, incomplete %0d",
                         status_hits[2], status_hits[3], status_hits[4]));
      $display("sentence kinds seen %0d of 11, field count saturated %0d times",
               kinds, sat_hits);
      if (mismatches == 0) begin
         $display("tb_nmea_sentence_validator: PASS");
      end else begin
         $display("tb_nmea_sentence_validator: FAIL");
      end
      $finish;
   end

endmodule
